[hdl/sdi_pkg.sv]
// sdi_pkg: types and constants shared by the sd card init sequencer
// depends on nothing; every other file in hdl uses it by scoped names
package sdi_pkg;

  // stream widths: fields packed from bit 0 up, zero filled to whole bytes
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 104;

  // transfer size in bytes
  localparam logic [31:0] BLOCK_BYTES = 32'd512;

  // sequencer phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_CMD0    = 4'd1;
  localparam logic [3:0] PH_CMD8    = 4'd2;
  localparam logic [3:0] PH_CMD55   = 4'd3;
  localparam logic [3:0] PH_ACMD41  = 4'd4;
  localparam logic [3:0] PH_CMD2    = 4'd5;
  localparam logic [3:0] PH_CMD3    = 4'd6;
  localparam logic [3:0] PH_CMD9    = 4'd7;
  localparam logic [3:0] PH_CMD7    = 4'd8;
  localparam logic [3:0] PH_CMD16   = 4'd9;
  localparam logic [3:0] PH_READY   = 4'd10;
  localparam logic [3:0] PH_NOCARD  = 4'd11;
  localparam logic [3:0] PH_ERROR   = 4'd12;
  localparam logic [3:0] PH_TIMEOUT = 4'd13;

  // item kinds
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_OUTCOME = 1'b1;

  // outcome codes of the last issued command
  localparam logic [1:0] OC_OK      = 2'd0;
  localparam logic [1:0] OC_TIMEOUT = 2'd1;

  // reported status
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_NOCARD  = 3'd2;
  localparam logic [2:0] ST_ERROR   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // expected response kinds
  localparam logic [1:0] RK_NONE      = 2'd0;
  localparam logic [1:0] RK_SHORT     = 2'd1;
  localparam logic [1:0] RK_LONG      = 2'd2;
  localparam logic [1:0] RK_SHORT_NCRC = 2'd3;

  // command indices
  localparam logic [5:0] SD_CMD0   = 6'd0;
  localparam logic [5:0] SD_CMD2   = 6'd2;
  localparam logic [5:0] SD_CMD3   = 6'd3;
  localparam logic [5:0] SD_CMD7   = 6'd7;
  localparam logic [5:0] SD_CMD8   = 6'd8;
  localparam logic [5:0] SD_CMD9   = 6'd9;
  localparam logic [5:0] SD_CMD16  = 6'd16;
  localparam logic [5:0] SD_ACMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55  = 6'd55;

  // command arguments and check pattern
  localparam logic [31:0] IF_COND_ARG   = 32'h0000_01AA;
  localparam logic [7:0]  CHECK_PATTERN = 8'hAA;
  localparam logic [31:0] OP_COND_ARG   = 32'h4030_0000;

  // configuration register indexes and reset values
  localparam logic [1:0] CFG_SLOW_DIV   = 2'd0;
  localparam logic [1:0] CFG_FAST_DIV   = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT = 2'd2;
  localparam logic [1:0] CFG_IF_TRIES   = 2'd3;

  localparam logic [9:0]  SLOW_DIV_RST   = 10'd26;
  localparam logic [9:0]  FAST_DIV_RST   = 10'd7;
  localparam logic [14:0] POLL_LIMIT_RST = 15'd20000;
  localparam logic [2:0]  IF_TRIES_RST   = 3'd3;

  // one input item
  typedef struct packed {
    logic        cmd;
    logic [1:0]  outcome;
    logic        card_present;
    logic [31:0] resp_first;
    logic [31:0] resp_second;
    logic [31:0] resp_third;
    logic [31:0] resp_fourth;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic        issue;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic [9:0]  clock_div;
    logic [2:0]  init_status;
    logic [15:0] card_address;
    logic        high_capacity;
    logic [32:0] capacity_blocks;
  } result_t;

  // configuration registers as seen by the core
  typedef struct packed {
    logic [9:0]  slow_clock_div;
    logic [9:0]  fast_clock_div;
    logic [14:0] ready_poll_limit;
    logic [2:0]  if_cond_tries;
  } cfg_t;

endpackage

[hdl/sd_card_init_sequencer.sv]
// sd card initialization sequencer: input register, step logic, result register
// path: an accepted item is held in the input register, then its result is loaded into the result register
// throughput: one item per cycle unless the result side stalls; s_tready is high while the
//   input register is empty or its item steps into a free or draining result register
// reset: rst clears phase and card state, loads register defaults, empties both stages
// depends on sdi_pkg, sdi_in_reg, sdi_core, sdi_out_reg
module sd_card_init_sequencer (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // outcome[1:0], card_present[2], resp_first[34:3], resp_second[66:35],
  // resp_third[98:67], resp_fourth[130:99], zero fill [135:131]
  input  logic [sdi_pkg::IN_TDATA_W-1:0] s_tdata,
  // cmd[0]
  input  logic        s_tuser,
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // cmd_index[5:0], cmd_arg[37:6], resp_kind[39:38], clock_div[49:40],
  // init_status[52:50], card_address[68:53], high_capacity[69],
  // capacity_blocks[102:70], zero fill [103]
  output logic [sdi_pkg::OUT_TDATA_W-1:0] m_tdata,
  // issue[0]
  output logic        m_tuser,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  sdi_pkg::in_item_t s_item, held_item;
  sdi_pkg::result_t  step_result, out_result;
  sdi_pkg::cfg_t     cfg;
  logic              held_valid, room, step;

  // unpack the input item
  always_comb begin
    s_item.cmd          = s_tuser;
    s_item.outcome      = s_tdata[1:0];
    s_item.card_present = s_tdata[2];
    s_item.resp_first   = s_tdata[34:3];
    s_item.resp_second  = s_tdata[66:35];
    s_item.resp_third   = s_tdata[98:67];
    s_item.resp_fourth  = s_tdata[130:99];
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_clock_div   <= sdi_pkg::SLOW_DIV_RST;
      cfg.fast_clock_div   <= sdi_pkg::FAST_DIV_RST;
      cfg.ready_poll_limit <= sdi_pkg::POLL_LIMIT_RST;
      cfg.if_cond_tries    <= sdi_pkg::IF_TRIES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sdi_pkg::CFG_SLOW_DIV:   cfg.slow_clock_div   <= cfg_data[9:0];
        sdi_pkg::CFG_FAST_DIV:   cfg.fast_clock_div   <= cfg_data[9:0];
        sdi_pkg::CFG_POLL_LIMIT: cfg.ready_poll_limit <= cfg_data;
        sdi_pkg::CFG_IF_TRIES:   cfg.if_cond_tries    <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // held item steps when the result register has room
  assign step = held_valid && room;

  sdi_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (s_item),
    .held_valid (held_valid),
    .held_take  (step),
    .held_item  (held_item)
  );

  sdi_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .cfg    (cfg),
    .result (step_result)
  );

  sdi_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (step),
    .room        (room),
    .next_result (step_result),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (out_result)
  );

  // pack the result item
  assign m_tuser = out_result.issue;
  assign m_tdata = {1'b0,
                    out_result.capacity_blocks,
                    out_result.high_capacity,
                    out_result.card_address,
                    out_result.init_status,
                    out_result.clock_div,
                    out_result.resp_kind,
                    out_result.cmd_arg,
                    out_result.cmd_index};

endmodule

[hdl/sdi_in_reg.sv]
// sdi_in_reg: input register stage holding one accepted item
// depends on sdi_pkg for the item type
module sdi_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdi_pkg::in_item_t in_item,
  output logic             held_valid,
  input  logic             held_take,
  output sdi_pkg::in_item_t held_item
);

  // room when empty or when the held item moves on this cycle
  assign in_ready = !held_valid || held_take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

[hdl/sdi_core.sv]
// sdi_core: sequencer state and the single-pass step from one item to one result
// depends on sdi_pkg for phases, codes, item and result types
module sdi_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  sdi_pkg::in_item_t item,
  input  sdi_pkg::cfg_t     cfg,
  output sdi_pkg::result_t  result
);

  logic [3:0]  phase, phase_next;
  logic [14:0] attempt_count, attempt_count_next;
  logic [15:0] rca_reg, rca_reg_next;
  logic        hc_flag, hc_flag_next;
  logic [32:0] block_count, block_count_next;
  logic        init_done, init_done_next;

  logic        issue;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_arg;
  logic [1:0]  resp_kind;
  logic [2:0]  status;
  logic        fail_timeout;
  logic [14:0] attempt_inc;

  // csd capacity, both formats
  logic [21:0] c_size_v2;
  logic [22:0] c_size_v2_inc;
  logic [32:0] blocks_v2;
  logic [11:0] c_size_v1;
  logic [32:0] c_size_v1_inc;
  logic [4:0]  size_exp;
  logic [32:0] blocks_v1;

  always_comb begin
    c_size_v2     = {item.resp_second[5:0], item.resp_third[31:16]};
    c_size_v2_inc = {1'b0, c_size_v2} + 23'd1;
    blocks_v2     = {c_size_v2_inc, 10'b0};
    c_size_v1     = {item.resp_second[9:0], item.resp_third[31:30]};
    c_size_v1_inc = {21'b0, c_size_v1} + 33'd1;
    size_exp      = {2'b0, item.resp_third[17:15]} + {1'b0, item.resp_second[19:16]} + 5'd2;
    // divide by the block size: shift left or right about nine
    if (size_exp >= 5'd9) begin
      blocks_v1 = c_size_v1_inc << (size_exp - 5'd9);
    end else begin
      blocks_v1 = c_size_v1_inc >> (5'd9 - size_exp);
    end
  end

  assign fail_timeout = (item.outcome == sdi_pkg::OC_TIMEOUT);
  assign attempt_inc  = attempt_count + 15'd1;

  // step: next command and state
  always_comb begin
    phase_next         = phase;
    attempt_count_next = attempt_count;
    rca_reg_next       = rca_reg;
    hc_flag_next       = hc_flag;
    block_count_next   = block_count;
    init_done_next     = init_done;
    issue              = 1'b0;
    cmd_index          = sdi_pkg::SD_CMD0;
    cmd_arg            = 32'd0;
    resp_kind          = sdi_pkg::RK_NONE;

    if (item.cmd == sdi_pkg::CMD_START) begin
      if (!init_done) begin
        rca_reg_next       = 16'd0;
        hc_flag_next       = 1'b0;
        block_count_next   = 33'd0;
        attempt_count_next = 15'd0;
        if (!item.card_present) begin
          phase_next = sdi_pkg::PH_NOCARD;
        end else begin
          issue      = 1'b1;
          phase_next = sdi_pkg::PH_CMD0;
        end
      end
    end else begin
      case (phase)
        sdi_pkg::PH_CMD0: begin
          if (item.outcome != sdi_pkg::OC_OK) begin
            phase_next = fail_timeout ? sdi_pkg::PH_TIMEOUT : sdi_pkg::PH_ERROR;
          end else begin
            attempt_count_next = 15'd0;
            issue      = 1'b1;
            cmd_index  = sdi_pkg::SD_CMD8;
            cmd_arg    = sdi_pkg::IF_COND_ARG;
            resp_kind  = sdi_pkg::RK_SHORT;
            phase_next = sdi_pkg::PH_CMD8;
          end
        end
        sdi_pkg::PH_CMD8: begin
          // retry the interface condition, then go on regardless
          issue     = 1'b1;
          resp_kind = sdi_pkg::RK_SHORT;
          if (item.outcome == sdi_pkg::OC_OK &&
              item.resp_first[7:0] == sdi_pkg::CHECK_PATTERN) begin
            attempt_count_next = 15'd0;
            cmd_index  = sdi_pkg::SD_CMD55;
            cmd_arg    = {rca_reg, 16'b0};
            phase_next = sdi_pkg::PH_CMD55;
          end else if (attempt_inc < {12'b0, cfg.if_cond_tries}) begin
            attempt_count_next = attempt_inc;
            cmd_index  = sdi_pkg::SD_CMD8;
            cmd_arg    = sdi_pkg::IF_COND_ARG;
            phase_next = sdi_pkg::PH_CMD8;
          end else begin
            attempt_count_next = 15'd0;
            cmd_index  = sdi_pkg::SD_CMD55;
            cmd_arg    = {rca_reg, 16'b0};
            phase_next = sdi_pkg::PH_CMD55;
          end
        end
        sdi_pkg::PH_CMD55: begin
          if (item.outcome != sdi_pkg::OC_OK) begin
            phase_next = fail_timeout ? sdi_pkg::PH_TIMEOUT : sdi_pkg::PH_ERROR;
          end else begin
            issue      = 1'b1;
            cmd_index  = sdi_pkg::SD_ACMD41;
            cmd_arg    = sdi_pkg::OP_COND_ARG;
            resp_kind  = sdi_pkg::RK_SHORT_NCRC;
            phase_next = sdi_pkg::PH_ACMD41;
          end
        end
        sdi_pkg::PH_ACMD41: begin
          // a crc failure on the ocr response still counts as a response
          if (fail_timeout) begin
            phase_next = sdi_pkg::PH_TIMEOUT;
          end else if (item.resp_first[31]) begin
            hc_flag_next = item.resp_first[30];
            issue        = 1'b1;
            cmd_index    = sdi_pkg::SD_CMD2;
            resp_kind    = sdi_pkg::RK_LONG;
            phase_next   = sdi_pkg::PH_CMD2;
          end else begin
            attempt_count_next = attempt_inc;
            if (attempt_inc >= cfg.ready_poll_limit) begin
              phase_next = sdi_pkg::PH_TIMEOUT;
            end else begin
              issue      = 1'b1;
              cmd_index  = sdi_pkg::SD_CMD55;
              cmd_arg    = {rca_reg, 16'b0};
              resp_kind  = sdi_pkg::RK_SHORT;
              phase_next = sdi_pkg::PH_CMD55;
            end
          end
        end
        sdi_pkg::PH_CMD2: begin
          if (item.outcome != sdi_pkg::OC_OK) begin
            phase_next = fail_timeout ? sdi_pkg::PH_TIMEOUT : sdi_pkg::PH_ERROR;
          end else begin
            issue      = 1'b1;
            cmd_index  = sdi_pkg::SD_CMD3;
            resp_kind  = sdi_pkg::RK_SHORT;
            phase_next = sdi_pkg::PH_CMD3;
          end
        end
        sdi_pkg::PH_CMD3: begin
          if (item.outcome != sdi_pkg::OC_OK) begin
            phase_next = fail_timeout ? sdi_pkg::PH_TIMEOUT : sdi_pkg::PH_ERROR;
          end else begin
            rca_reg_next = item.resp_first[31:16];
            issue        = 1'b1;
            cmd_index    = sdi_pkg::SD_CMD9;
            cmd_arg      = {item.resp_first[31:16], 16'b0};
            resp_kind    = sdi_pkg::RK_LONG;
            phase_next   = sdi_pkg::PH_CMD9;
          end
        end
        sdi_pkg::PH_CMD9: begin
          if (item.outcome != sdi_pkg::OC_OK) begin
            phase_next = fail_timeout ? sdi_pkg::PH_TIMEOUT : sdi_pkg::PH_ERROR;
          end else begin
            block_count_next = hc_flag ? blocks_v2 : blocks_v1;
            issue      = 1'b1;
            cmd_index  = sdi_pkg::SD_CMD7;
            cmd_arg    = {rca_reg, 16'b0};
            resp_kind  = sdi_pkg::RK_SHORT;
            phase_next = sdi_pkg::PH_CMD7;
          end
        end
        sdi_pkg::PH_CMD7: begin
          if (item.outcome != sdi_pkg::OC_OK) begin
            phase_next = fail_timeout ? sdi_pkg::PH_TIMEOUT : sdi_pkg::PH_ERROR;
          end else begin
            issue      = 1'b1;
            cmd_index  = sdi_pkg::SD_CMD16;
            cmd_arg    = sdi_pkg::BLOCK_BYTES;
            resp_kind  = sdi_pkg::RK_SHORT;
            phase_next = sdi_pkg::PH_CMD16;
          end
        end
        sdi_pkg::PH_CMD16: begin
          if (item.outcome != sdi_pkg::OC_OK) begin
            phase_next = fail_timeout ? sdi_pkg::PH_TIMEOUT : sdi_pkg::PH_ERROR;
          end else begin
            phase_next     = sdi_pkg::PH_READY;
            init_done_next = 1'b1;
          end
        end
        default: begin
          // idle or stopped: outcome ignored
        end
      endcase
    end
  end

  // status from the updated state
  always_comb begin
    if (init_done_next || phase_next == sdi_pkg::PH_READY) begin
      status = sdi_pkg::ST_READY;
    end else if (phase_next == sdi_pkg::PH_NOCARD) begin
      status = sdi_pkg::ST_NOCARD;
    end else if (phase_next == sdi_pkg::PH_ERROR) begin
      status = sdi_pkg::ST_ERROR;
    end else if (phase_next == sdi_pkg::PH_TIMEOUT) begin
      status = sdi_pkg::ST_TIMEOUT;
    end else begin
      status = sdi_pkg::ST_BUSY;
    end
  end

  // result item
  always_comb begin
    result.issue           = issue;
    result.cmd_index       = cmd_index;
    result.cmd_arg         = cmd_arg;
    result.resp_kind       = resp_kind;
    result.clock_div       = (status == sdi_pkg::ST_READY) ? cfg.fast_clock_div
                                                           : cfg.slow_clock_div;
    result.init_status     = status;
    result.card_address    = rca_reg_next;
    result.high_capacity   = hc_flag_next;
    result.capacity_blocks = block_count_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sdi_pkg::PH_IDLE;
      attempt_count <= 15'd0;
      rca_reg       <= 16'd0;
      hc_flag       <= 1'b0;
      block_count   <= 33'd0;
      init_done     <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      attempt_count <= attempt_count_next;
      rca_reg       <= rca_reg_next;
      hc_flag       <= hc_flag_next;
      block_count   <= block_count_next;
      init_done     <= init_done_next;
    end
  end

endmodule

[hdl/sdi_out_reg.sv]
// sdi_out_reg: result register, holds one result until the sink takes it
// depends on sdi_pkg for the result type
module sdi_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  output logic             room,
  input  sdi_pkg::result_t next_result,
  output logic             out_valid,
  input  logic             out_ready,
  output sdi_pkg::result_t out_result
);

  // free when empty or drained this cycle
  assign room = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= next_result;
    end
  end

endmodule

[hdl/sdi_checker.sv]
// sdi_checker: port-level checks on the sequencer, bound to the top level
// depends on sdi_pkg for status and command codes
module sdi_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [sdi_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic        m_tuser
);

  // no result straight after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a command is only issued while the sequence is busy
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[52:50] == sdi_pkg::ST_BUSY)
    else $error("command issued outside busy status");

  // go-idle only goes out with card state cleared
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && m_tdata[5:0] == sdi_pkg::SD_CMD0
      |-> m_tdata[68:53] == 16'd0 && m_tdata[102:70] == 33'd0 && !m_tdata[69])
    else $error("go-idle with stale card state");

endmodule

bind sd_card_init_sequencer sdi_checker u_sdi_checker (.*);

[bench/sd_card_init_sequencer_tb.sv]
`timescale 1ns / 100ps
// self-checking bench for the sd card init sequencer: stream driver, stream monitor,
// command flow predictor and register writes between phases
// depends on sdi_pkg and the sd_card_init_sequencer top level
module sd_card_init_sequencer_tb;

  // outcome codes that the package leaves unnamed
  localparam logic [1:0] OC_CRC_FAIL = 2'd2;
  localparam logic [1:0] OC_CODE3    = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [sdi_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [sdi_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [1:0]                      cfg_index = sdi_pkg::CFG_SLOW_DIV;
  logic [14:0]                     cfg_data = '0;

  sd_card_init_sequencer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted sequencer state, starting from its reset values
  logic [3:0]  seq_phase   = sdi_pkg::PH_IDLE;
  logic [14:0] tries_used  = '0;
  logic [15:0] card_rca    = '0;
  logic        card_hc     = 1'b0;
  logic [32:0] card_blocks = '0;
  logic        card_ready  = 1'b0;

  // register copies
  logic [9:0]  div_slow   = sdi_pkg::SLOW_DIV_RST;
  logic [9:0]  div_fast   = sdi_pkg::FAST_DIV_RST;
  logic [14:0] poll_limit = sdi_pkg::POLL_LIMIT_RST;
  logic [2:0]  cond_tries = sdi_pkg::IF_TRIES_RST;

  sdi_pkg::in_item_t item_backlog[$];
  sdi_pkg::result_t  awaited_replies[$];
  sdi_pkg::in_item_t next_item;
  sdi_pkg::in_item_t seen_item;
  sdi_pkg::result_t  got_reply;
  sdi_pkg::result_t  want_reply;

  int mismatches     = 0;
  int accepted_items = 0;
  int live_items     = 0;
  int src_gap_max    = 16;
  int sink_stall_max = 16;
  int src_wait       = 0;
  int sink_wait      = 0;
  int sink_draw;
  logic hold_off = 1'b0;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("sd_card_init_sequencer regression: fail");
    $finish;
  end

  function automatic int draw_wait(input int max_wait);
    if (max_wait == 0 || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, max_wait);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 50)
      $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // command flow prediction
  function automatic logic [3:0] failed_phase(input logic [1:0] oc);
    return (oc == sdi_pkg::OC_TIMEOUT) ? sdi_pkg::PH_TIMEOUT : sdi_pkg::PH_ERROR;
  endfunction

  function automatic void issue_cmd(inout sdi_pkg::result_t r, input logic [5:0] idx,
                                    input logic [31:0] arg, input logic [1:0] kind,
                                    input logic [3:0] ph);
    r.issue     = 1'b1;
    r.cmd_index = idx;
    r.cmd_arg   = arg;
    r.resp_kind = kind;
    seq_phase   = ph;
  endfunction

  function automatic sdi_pkg::result_t sequencer_step(input sdi_pkg::in_item_t it);
    sdi_pkg::result_t r;
    logic [2:0]       status;
    logic [32:0]      c_size;
    logic [4:0]       expo;
    r = '0;
    if (it.cmd == sdi_pkg::CMD_START) begin
      if (!card_ready) begin
        card_rca    = '0;
        card_hc     = 1'b0;
        card_blocks = '0;
        tries_used  = '0;
        if (!it.card_present) seq_phase = sdi_pkg::PH_NOCARD;
        else issue_cmd(r, sdi_pkg::SD_CMD0, 32'h0, sdi_pkg::RK_NONE, sdi_pkg::PH_CMD0);
      end
    end else begin
      case (seq_phase)
        sdi_pkg::PH_CMD0: begin
          if (it.outcome != sdi_pkg::OC_OK) seq_phase = failed_phase(it.outcome);
          else begin
            tries_used = '0;
            issue_cmd(r, sdi_pkg::SD_CMD8, sdi_pkg::IF_COND_ARG, sdi_pkg::RK_SHORT,
                      sdi_pkg::PH_CMD8);
          end
        end
        // interface condition: failure costs a retry, or moves on once the tries are used up
        sdi_pkg::PH_CMD8: begin
          if (it.outcome == sdi_pkg::OC_OK &&
              it.resp_first[7:0] == sdi_pkg::CHECK_PATTERN) begin
            tries_used = '0;
            issue_cmd(r, sdi_pkg::SD_CMD55, {card_rca, 16'h0}, sdi_pkg::RK_SHORT,
                      sdi_pkg::PH_CMD55);
          end else begin
            tries_used = tries_used + 15'd1;
            if (tries_used < {12'd0, cond_tries})
              issue_cmd(r, sdi_pkg::SD_CMD8, sdi_pkg::IF_COND_ARG, sdi_pkg::RK_SHORT,
                        sdi_pkg::PH_CMD8);
            else begin
              tries_used = '0;
              issue_cmd(r, sdi_pkg::SD_CMD55, {card_rca, 16'h0}, sdi_pkg::RK_SHORT,
                        sdi_pkg::PH_CMD55);
            end
          end
        end
        sdi_pkg::PH_CMD55: begin
          if (it.outcome != sdi_pkg::OC_OK) seq_phase = failed_phase(it.outcome);
          else issue_cmd(r, sdi_pkg::SD_ACMD41, sdi_pkg::OP_COND_ARG,
                         sdi_pkg::RK_SHORT_NCRC, sdi_pkg::PH_ACMD41);
        end
        // crc failure on the ocr word still counts as a response
        sdi_pkg::PH_ACMD41: begin
          if (it.outcome == sdi_pkg::OC_TIMEOUT) seq_phase = sdi_pkg::PH_TIMEOUT;
          else if (it.resp_first[31]) begin
            card_hc = it.resp_first[30];
            issue_cmd(r, sdi_pkg::SD_CMD2, 32'h0, sdi_pkg::RK_LONG, sdi_pkg::PH_CMD2);
          end else begin
            tries_used = tries_used + 15'd1;
            if (tries_used >= poll_limit) seq_phase = sdi_pkg::PH_TIMEOUT;
            else issue_cmd(r, sdi_pkg::SD_CMD55, {card_rca, 16'h0}, sdi_pkg::RK_SHORT,
                           sdi_pkg::PH_CMD55);
          end
        end
        sdi_pkg::PH_CMD2: begin
          if (it.outcome != sdi_pkg::OC_OK) seq_phase = failed_phase(it.outcome);
          else issue_cmd(r, sdi_pkg::SD_CMD3, 32'h0, sdi_pkg::RK_SHORT, sdi_pkg::PH_CMD3);
        end
        sdi_pkg::PH_CMD3: begin
          if (it.outcome != sdi_pkg::OC_OK) seq_phase = failed_phase(it.outcome);
          else begin
            card_rca = it.resp_first[31:16];
            issue_cmd(r, sdi_pkg::SD_CMD9, {card_rca, 16'h0}, sdi_pkg::RK_LONG,
                      sdi_pkg::PH_CMD9);
          end
        end
        // csd capacity, version 2 layout for high capacity cards, version 1 layout otherwise
        sdi_pkg::PH_CMD9: begin
          if (it.outcome != sdi_pkg::OC_OK) seq_phase = failed_phase(it.outcome);
          else begin
            if (card_hc) begin
              c_size = {11'd0, it.resp_second[5:0], it.resp_third[31:16]};
              card_blocks = (c_size + 33'd1) << 10;
            end else begin
              c_size = {21'd0, it.resp_second[9:0], it.resp_third[31:30]};
              expo = 5'd2 + {2'd0, it.resp_third[17:15]} + {1'd0, it.resp_second[19:16]};
              if (expo >= 5'd9) card_blocks = (c_size + 33'd1) << (expo - 5'd9);
              else card_blocks = (c_size + 33'd1) >> (5'd9 - expo);
            end
            issue_cmd(r, sdi_pkg::SD_CMD7, {card_rca, 16'h0}, sdi_pkg::RK_SHORT,
                      sdi_pkg::PH_CMD7);
          end
        end
        sdi_pkg::PH_CMD7: begin
          if (it.outcome != sdi_pkg::OC_OK) seq_phase = failed_phase(it.outcome);
          else issue_cmd(r, sdi_pkg::SD_CMD16, sdi_pkg::BLOCK_BYTES, sdi_pkg::RK_SHORT,
                         sdi_pkg::PH_CMD16);
        end
        sdi_pkg::PH_CMD16: begin
          if (it.outcome != sdi_pkg::OC_OK) seq_phase = failed_phase(it.outcome);
          else begin
            seq_phase  = sdi_pkg::PH_READY;
            card_ready = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (card_ready || seq_phase == sdi_pkg::PH_READY) status = sdi_pkg::ST_READY;
    else if (seq_phase == sdi_pkg::PH_NOCARD) status = sdi_pkg::ST_NOCARD;
    else if (seq_phase == sdi_pkg::PH_ERROR) status = sdi_pkg::ST_ERROR;
    else if (seq_phase == sdi_pkg::PH_TIMEOUT) status = sdi_pkg::ST_TIMEOUT;
    else status = sdi_pkg::ST_BUSY;
    r.init_status     = status;
    r.clock_div       = (status == sdi_pkg::ST_READY) ? div_fast : div_slow;
    r.card_address    = card_rca;
    r.high_capacity   = card_hc;
    r.capacity_blocks = card_blocks;
    return r;
  endfunction

  // item builders
  function automatic void push_item(input logic cmd, input logic [1:0] oc,
                                    input logic present, input logic [31:0] w0,
                                    input logic [31:0] w1, input logic [31:0] w2,
                                    input logic [31:0] w3);
    sdi_pkg::in_item_t it;
    it.cmd          = cmd;
    it.outcome      = oc;
    it.card_present = present;
    it.resp_first   = w0;
    it.resp_second  = w1;
    it.resp_third   = w2;
    it.resp_fourth  = w3;
    item_backlog.push_back(it);
  endfunction

  function automatic void push_reply(input logic [1:0] oc, input logic [31:0] w0);
    push_item(sdi_pkg::CMD_OUTCOME, oc, 1'($urandom_range(0, 1)), w0, $urandom, $urandom,
              $urandom);
    live_items++;
  endfunction

  function automatic void push_start(input logic present);
    push_item(sdi_pkg::CMD_START, 2'($urandom_range(0, 2)), present, $urandom, $urandom,
              $urandom, $urandom);
    live_items++;
  endfunction

  // outcome that the sequencer will most likely ignore
  function automatic void push_noise();
    push_item(sdi_pkg::CMD_OUTCOME, 2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
              $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic logic [1:0] fail_code();
    return $urandom_range(0, 1) ? sdi_pkg::OC_TIMEOUT : OC_CRC_FAIL;
  endfunction

  function automatic logic [1:0] ok_or_crc();
    return $urandom_range(0, 1) ? sdi_pkg::OC_OK : OC_CRC_FAIL;
  endfunction

  // now and then break the sequence off with a failure, a restart or a pulled card
  function automatic bit derail(input bit to_ready);
    if (to_ready || $urandom_range(0, 13) != 0) return 1'b0;
    case ($urandom_range(0, 2))
      0: push_reply(fail_code(), $urandom);
      1: push_start(1'b1);
      default: push_start(1'b0);
    endcase
    push_noise();
    return 1'b1;
  endfunction

  // one identification run with random content, optionally completed to ready
  task automatic queue_sequence(input bit to_ready);
    int n_if;
    int n_poll;
    int lim;
    logic [31:0] w;
    lim = int'(poll_limit);
    if (!to_ready && $urandom_range(0, 7) == 0) push_noise();
    if (!to_ready && $urandom_range(0, 11) == 0) begin
      push_start(1'b0);
      push_noise();
      return;
    end
    push_start(1'b1);
    if (derail(to_ready)) return;
    push_reply(sdi_pkg::OC_OK, $urandom);
    if (derail(to_ready)) return;

    // interface condition attempts
    n_if = $urandom_range(0, cond_tries);
    for (int i = 0; i < n_if; i++) begin
      w = $urandom;
      if (w[7:0] == sdi_pkg::CHECK_PATTERN) w[0] = ~w[0];
      push_reply(2'($urandom_range(0, 2)), w);
    end
    if (n_if < int'(cond_tries)) begin
      w = $urandom;
      w[7:0] = sdi_pkg::CHECK_PATTERN;
      push_reply(sdi_pkg::OC_OK, w);
    end
    if (derail(to_ready)) return;

    // busy rounds of the op condition loop
    if (to_ready) n_poll = $urandom_range(0, (lim > 3) ? 3 : lim - 1);
    else if (lim <= 8 && $urandom_range(0, 3) == 0) n_poll = lim;
    else n_poll = $urandom_range(0, (lim < 4) ? lim : 4);
    for (int i = 0; i < n_poll; i++) begin
      push_reply(sdi_pkg::OC_OK, $urandom);
      w = $urandom;
      w[31] = 1'b0;
      push_reply(ok_or_crc(), w);
      if (i + 1 >= lim) begin
        push_noise();
        return;
      end
      if (derail(to_ready)) return;
    end
    push_reply(sdi_pkg::OC_OK, $urandom);
    w = $urandom;
    w[31] = 1'b1;
    push_reply(ok_or_crc(), w);
    if (derail(to_ready)) return;

    // cid, rca, csd, select
    push_reply(sdi_pkg::OC_OK, $urandom);
    if (derail(to_ready)) return;
    push_reply(sdi_pkg::OC_OK, $urandom);
    if (derail(to_ready)) return;
    push_reply(sdi_pkg::OC_OK, $urandom);
    if (derail(to_ready)) return;
    push_reply(sdi_pkg::OC_OK, $urandom);
    if (derail(to_ready)) return;

    // block length: only the last run is let through to ready
    push_reply(to_ready ? sdi_pkg::OC_OK : fail_code(), $urandom);
    if (!to_ready) push_noise();
  endtask

  // register writes
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sdi_pkg::CFG_SLOW_DIV:   div_slow   = value[9:0];
      sdi_pkg::CFG_FAST_DIV:   div_fast   = value[9:0];
      sdi_pkg::CFG_POLL_LIMIT: poll_limit = value;
      sdi_pkg::CFG_IF_TRIES:   cond_tries = value[2:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry random filler
  task automatic set_config(input logic [9:0] slow, input logic [9:0] fast,
                            input logic [14:0] poll, input logic [2:0] tries);
    write_reg(sdi_pkg::CFG_SLOW_DIV, {5'($urandom), slow});
    write_reg(sdi_pkg::CFG_FAST_DIV, {5'($urandom), fast});
    write_reg(sdi_pkg::CFG_POLL_LIMIT, poll);
    write_reg(sdi_pkg::CFG_IF_TRIES, {12'($urandom), tries});
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (item_backlog.size() != 0 || s_tvalid || awaited_replies.size() != 0);
  endtask

  // stream driver fed from the backlog
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_wait != 0) begin
        s_tvalid <= 1'b0;
        src_wait <= src_wait - 1;
      end else if (item_backlog.size() != 0) begin
        next_item = item_backlog.pop_front();
        s_tuser  <= next_item.cmd;
        s_tdata  <= {5'd0, next_item.resp_fourth, next_item.resp_third,
                     next_item.resp_second, next_item.resp_first,
                     next_item.card_present, next_item.outcome};
        s_tvalid <= 1'b1;
        src_wait <= draw_wait(src_gap_max);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_wait <= 0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      sink_draw = draw_wait(sink_stall_max);
      sink_wait <= sink_draw;
      m_tready  <= (sink_draw == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_tready  <= (sink_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // hold the result side off long enough for the block to fill and stall its input
  initial begin
    do @(negedge clk); while (!(accepted_items >= 300 && item_backlog.size() > 20));
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // monitor: check results against the oldest prediction, then predict new items
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_reply.issue           = m_tuser;
        got_reply.cmd_index       = m_tdata[5:0];
        got_reply.cmd_arg         = m_tdata[37:6];
        got_reply.resp_kind       = m_tdata[39:38];
        got_reply.clock_div       = m_tdata[49:40];
        got_reply.init_status     = m_tdata[52:50];
        got_reply.card_address    = m_tdata[68:53];
        got_reply.high_capacity   = m_tdata[69];
        got_reply.capacity_blocks = m_tdata[102:70];
        if (awaited_replies.size() == 0) begin
          report_mismatch("result with nothing awaited", m_tdata[63:0], '0);
        end else begin
          want_reply = awaited_replies.pop_front();
          check_field("issue", 64'(got_reply.issue), 64'(want_reply.issue));
          check_field("cmd_index", 64'(got_reply.cmd_index), 64'(want_reply.cmd_index));
          check_field("cmd_arg", 64'(got_reply.cmd_arg), 64'(want_reply.cmd_arg));
          check_field("resp_kind", 64'(got_reply.resp_kind), 64'(want_reply.resp_kind));
          check_field("clock_div", 64'(got_reply.clock_div), 64'(want_reply.clock_div));
          check_field("init_status", 64'(got_reply.init_status),
                      64'(want_reply.init_status));
          check_field("card_address", 64'(got_reply.card_address),
                      64'(want_reply.card_address));
          check_field("high_capacity", 64'(got_reply.high_capacity),
                      64'(want_reply.high_capacity));
          check_field("capacity_blocks", 64'(got_reply.capacity_blocks),
                      64'(want_reply.capacity_blocks));
        end
      end
      if (s_tvalid && s_tready) begin
        seen_item.cmd          = s_tuser;
        seen_item.outcome      = s_tdata[1:0];
        seen_item.card_present = s_tdata[2];
        seen_item.resp_first   = s_tdata[34:3];
        seen_item.resp_second  = s_tdata[66:35];
        seen_item.resp_third   = s_tdata[98:67];
        seen_item.resp_fourth  = s_tdata[130:99];
        awaited_replies.push_back(sequencer_step(seen_item));
        accepted_items++;
      end
    end
  end

  // stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed run on reset register values
    // outcome while idle
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    // no card
    push_item(sdi_pkg::CMD_START, sdi_pkg::OC_OK, 1'b0, '1, '1, '1, '1);
    // ignored while stopped
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '1, '1, '1, '1);
    push_item(sdi_pkg::CMD_START, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    // bad check pattern
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b0, 32'h0000_01AB, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_TIMEOUT, 1'b1, 32'h0000_01AA, '0, '0, '0);
    // tries used up
    push_item(sdi_pkg::CMD_OUTCOME, OC_CRC_FAIL, 1'b1, 32'h0000_01AA, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    // card still busy
    push_item(sdi_pkg::CMD_OUTCOME, OC_CRC_FAIL, 1'b1, 32'h7FFF_FFFF, '1, '1, '1);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    // ready despite crc
    push_item(sdi_pkg::CMD_OUTCOME, OC_CRC_FAIL, 1'b0, 32'hC0FF_8000, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '1, '1, '1, '1);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, 32'hFFFF_0000, '0, '0, '0);
    // largest v2 capacity
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '1, '1, '1, '1);
    // code 3 as crc failure
    push_item(sdi_pkg::CMD_OUTCOME, OC_CODE3, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_START, sdi_pkg::OC_TIMEOUT, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_TIMEOUT, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_START, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, 32'h0000_01AA, '0, '0, '0);
    // restart mid sequence
    push_item(sdi_pkg::CMD_START, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, 32'hFFFF_FFAA, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_OK, 1'b1, '0, '0, '0, '0);
    push_item(sdi_pkg::CMD_OUTCOME, sdi_pkg::OC_TIMEOUT, 1'b1, 32'h8000_0000, '0, '0, '0);
    wait_idle();

    // random phases, each on its own register setting
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: set_config(10'd0, 10'd1023, 15'd1, 3'd1);
        1: set_config(10'd1023, 10'd0, 15'd32767, 3'd7);
        default: set_config(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                            15'($urandom_range(1, 5)), 3'($urandom_range(1, 7)));
      endcase
      src_gap_max    = (k == 2) ? 0 : 16;
      sink_stall_max = (k == 2 || k == 4) ? 0 : 16;
      live_items = 0;
      while (live_items < 170) queue_sequence(1'b0);
      wait_idle();
    end

    // finish one card all the way, then prod the initialised block
    src_gap_max    = 16;
    sink_stall_max = 16;
    set_config(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), 15'd3, 3'd2);
    queue_sequence(1'b1);
    push_start(1'b1);
    push_start(1'b0);
    push_noise();
    push_noise();
    wait_idle();
    set_config(10'd0, 10'd1023, 15'd32767, 3'd7);
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 1)) push_start(1'($urandom_range(0, 1)));
      else push_noise();
    end
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("sd_card_init_sequencer regression: pass");
    end else begin
      $display("sd_card_init_sequencer regression: fail");
    end
    $finish;
  end

endmodule
